>>> sv/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg: shared types and constants
// Sequencer states, operand store map and the micro-program of the
// circumsphere depth counter.
// ----------------------------------------------------------------------------
package csd_pkg;

	localparam int W      = 128;
	localparam int ADDR_W = 6;
	localparam int PC_W   = 7;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [PC_W-1:0]   pc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRIN,
		ST_FETCH,
		ST_SETUP,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		K_PLAIN,
		K_DELTA,
		K_CHK,
		K_INSIDE,
		K_SIDE
	} kind_t;

	typedef struct packed {
		addr_t a;
		addr_t b;
		logic  bone;
		logic  clr;
		logic  neg;
		logic  wr;
		addr_t dst;
		kind_t kind;
	} uop_t;

	typedef struct packed {
		logic start;
		logic bone;
		logic clr;
		logic neg;
	} mac_ctl_t;

	localparam logic       REQ_LOAD = 1'b0;
	localparam logic       REQ_TEST = 1'b1;
	localparam logic [1:0] SIDE_IN  = 2'd0;
	localparam logic [1:0] SIDE_ON  = 2'd1;
	localparam logic [1:0] SIDE_OUT = 2'd2;
	localparam logic [1:0] SGN_ZERO = 2'd0;
	localparam logic [1:0] SGN_POS  = 2'd1;
	localparam logic [1:0] SGN_NEG  = 2'd3;

	localparam addr_t A_V0  = 6'd0;
	localparam addr_t A_V1  = 6'd3;
	localparam addr_t A_V2  = 6'd6;
	localparam addr_t A_V3  = 6'd9;
	localparam addr_t A_Z   = 6'd12;
	localparam addr_t A_U   = 6'd15;
	localparam addr_t A_V   = 6'd18;
	localparam addr_t A_W   = 6'd21;
	localparam addr_t A_VW  = 6'd24;
	localparam addr_t A_WU  = 6'd27;
	localparam addr_t A_UV  = 6'd30;
	localparam addr_t A_DLT = 6'd33;
	localparam addr_t A_UU  = 6'd34;
	localparam addr_t A_VV  = 6'd35;
	localparam addr_t A_WW  = 6'd36;
	localparam addr_t A_N   = 6'd37;
	localparam addr_t A_LB  = 6'd40;
	localparam addr_t A_LC  = 6'd41;
	localparam addr_t A_LD  = 6'd42;
	localparam addr_t A_TSQ = 6'd43;
	localparam addr_t A_TW  = 6'd44;
	localparam addr_t A_DF  = 6'd45;
	localparam addr_t A_D   = 6'd46;
	localparam addr_t A_DD  = 6'd49;
	localparam addr_t A_F   = 6'd50;

	localparam pc_t PC_LOAD = 7'd0;
	localparam pc_t PC_SIDE = 7'd73;

	function automatic addr_t ax(addr_t base, int k);
		return addr_t'(int'(base) + k);
	endfunction

	function automatic uop_t mk(addr_t a, addr_t b, int bone, int clr, int neg,
		int wr, addr_t dst, kind_t kind);
		uop_t u;
		u.a = a; u.b = b; u.bone = 1'(bone); u.clr = 1'(clr); u.neg = 1'(neg);
		u.wr = 1'(wr); u.dst = dst; u.kind = kind;
		return u;
	endfunction

	function automatic uop_t rom(pc_t pc);
		uop_t u;
		u = mk(A_V0, A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
		case (pc)
			// Edge vectors from the reference vertex.
			7'd0:  u = mk(ax(A_V1,0), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd1:  u = mk(ax(A_V0,0), A_V0, 1, 0, 1, 1, ax(A_U,0), K_PLAIN);
			7'd2:  u = mk(ax(A_V1,1), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd3:  u = mk(ax(A_V0,1), A_V0, 1, 0, 1, 1, ax(A_U,1), K_PLAIN);
			7'd4:  u = mk(ax(A_V1,2), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd5:  u = mk(ax(A_V0,2), A_V0, 1, 0, 1, 1, ax(A_U,2), K_PLAIN);
			7'd6:  u = mk(ax(A_V2,0), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd7:  u = mk(ax(A_V0,0), A_V0, 1, 0, 1, 1, ax(A_V,0), K_PLAIN);
			7'd8:  u = mk(ax(A_V2,1), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd9:  u = mk(ax(A_V0,1), A_V0, 1, 0, 1, 1, ax(A_V,1), K_PLAIN);
			7'd10: u = mk(ax(A_V2,2), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd11: u = mk(ax(A_V0,2), A_V0, 1, 0, 1, 1, ax(A_V,2), K_PLAIN);
			7'd12: u = mk(ax(A_V3,0), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd13: u = mk(ax(A_V0,0), A_V0, 1, 0, 1, 1, ax(A_W,0), K_PLAIN);
			7'd14: u = mk(ax(A_V3,1), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd15: u = mk(ax(A_V0,1), A_V0, 1, 0, 1, 1, ax(A_W,1), K_PLAIN);
			7'd16: u = mk(ax(A_V3,2), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd17: u = mk(ax(A_V0,2), A_V0, 1, 0, 1, 1, ax(A_W,2), K_PLAIN);
			// Cross products v x w, w x u and u x v.
			7'd18: u = mk(ax(A_V,1), ax(A_W,2), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd19: u = mk(ax(A_V,2), ax(A_W,1), 0, 0, 1, 1, ax(A_VW,0), K_PLAIN);
			7'd20: u = mk(ax(A_V,2), ax(A_W,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd21: u = mk(ax(A_V,0), ax(A_W,2), 0, 0, 1, 1, ax(A_VW,1), K_PLAIN);
			7'd22: u = mk(ax(A_V,0), ax(A_W,1), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd23: u = mk(ax(A_V,1), ax(A_W,0), 0, 0, 1, 1, ax(A_VW,2), K_PLAIN);
			7'd24: u = mk(ax(A_W,1), ax(A_U,2), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd25: u = mk(ax(A_W,2), ax(A_U,1), 0, 0, 1, 1, ax(A_WU,0), K_PLAIN);
			7'd26: u = mk(ax(A_W,2), ax(A_U,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd27: u = mk(ax(A_W,0), ax(A_U,2), 0, 0, 1, 1, ax(A_WU,1), K_PLAIN);
			7'd28: u = mk(ax(A_W,0), ax(A_U,1), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd29: u = mk(ax(A_W,1), ax(A_U,0), 0, 0, 1, 1, ax(A_WU,2), K_PLAIN);
			7'd30: u = mk(ax(A_U,1), ax(A_V,2), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd31: u = mk(ax(A_U,2), ax(A_V,1), 0, 0, 1, 1, ax(A_UV,0), K_PLAIN);
			7'd32: u = mk(ax(A_U,2), ax(A_V,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd33: u = mk(ax(A_U,0), ax(A_V,2), 0, 0, 1, 1, ax(A_UV,1), K_PLAIN);
			7'd34: u = mk(ax(A_U,0), ax(A_V,1), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd35: u = mk(ax(A_U,1), ax(A_V,0), 0, 0, 1, 1, ax(A_UV,2), K_PLAIN);
			// Orientation determinant.
			7'd36: u = mk(ax(A_VW,0), ax(A_U,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd37: u = mk(ax(A_VW,1), ax(A_U,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd38: u = mk(ax(A_VW,2), ax(A_U,2), 0, 0, 0, 1, A_DLT, K_DELTA);
			// Squared edge lengths.
			7'd39: u = mk(ax(A_U,0), ax(A_U,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd40: u = mk(ax(A_U,1), ax(A_U,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd41: u = mk(ax(A_U,2), ax(A_U,2), 0, 0, 0, 1, A_UU, K_PLAIN);
			7'd42: u = mk(ax(A_V,0), ax(A_V,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd43: u = mk(ax(A_V,1), ax(A_V,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd44: u = mk(ax(A_V,2), ax(A_V,2), 0, 0, 0, 1, A_VV, K_PLAIN);
			7'd45: u = mk(ax(A_W,0), ax(A_W,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd46: u = mk(ax(A_W,1), ax(A_W,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd47: u = mk(ax(A_W,2), ax(A_W,2), 0, 0, 0, 1, A_WW, K_PLAIN);
			// Circumcentre numerator vector.
			7'd48: u = mk(A_UU, ax(A_VW,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd49: u = mk(A_VV, ax(A_WU,0), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd50: u = mk(A_WW, ax(A_UV,0), 0, 0, 0, 1, ax(A_N,0), K_PLAIN);
			7'd51: u = mk(A_UU, ax(A_VW,1), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd52: u = mk(A_VV, ax(A_WU,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd53: u = mk(A_WW, ax(A_UV,1), 0, 0, 0, 1, ax(A_N,1), K_PLAIN);
			7'd54: u = mk(A_UU, ax(A_VW,2), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd55: u = mk(A_VV, ax(A_WU,2), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd56: u = mk(A_WW, ax(A_UV,2), 0, 0, 0, 1, ax(A_N,2), K_PLAIN);
			// Barycentric weights of the centre.
			7'd57: u = mk(ax(A_N,0), ax(A_VW,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd58: u = mk(ax(A_N,1), ax(A_VW,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd59: u = mk(ax(A_N,2), ax(A_VW,2), 0, 0, 0, 1, A_LB, K_CHK);
			7'd60: u = mk(ax(A_N,0), ax(A_WU,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd61: u = mk(ax(A_N,1), ax(A_WU,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd62: u = mk(ax(A_N,2), ax(A_WU,2), 0, 0, 0, 1, A_LC, K_CHK);
			7'd63: u = mk(ax(A_N,0), ax(A_UV,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd64: u = mk(ax(A_N,1), ax(A_UV,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd65: u = mk(ax(A_N,2), ax(A_UV,2), 0, 0, 0, 1, A_LD, K_CHK);
			7'd66: u = mk(A_DLT, A_DLT, 0, 1, 0, 1, A_TSQ, K_PLAIN);
			7'd67: u = mk(A_TSQ, A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd68: u = mk(A_TSQ, A_V0, 1, 0, 0, 1, A_TW, K_PLAIN);
			7'd69: u = mk(A_TW, A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd70: u = mk(A_LB, A_V0, 1, 0, 1, 0, A_V0, K_PLAIN);
			7'd71: u = mk(A_LC, A_V0, 1, 0, 1, 0, A_V0, K_PLAIN);
			7'd72: u = mk(A_LD, A_V0, 1, 0, 1, 1, A_DF, K_INSIDE);
			// Point test.
			7'd73: u = mk(ax(A_Z,0), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd74: u = mk(ax(A_V0,0), A_V0, 1, 0, 1, 1, ax(A_D,0), K_PLAIN);
			7'd75: u = mk(ax(A_Z,1), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd76: u = mk(ax(A_V0,1), A_V0, 1, 0, 1, 1, ax(A_D,1), K_PLAIN);
			7'd77: u = mk(ax(A_Z,2), A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
			7'd78: u = mk(ax(A_V0,2), A_V0, 1, 0, 1, 1, ax(A_D,2), K_PLAIN);
			7'd79: u = mk(ax(A_D,0), ax(A_D,0), 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd80: u = mk(ax(A_D,1), ax(A_D,1), 0, 0, 0, 0, A_V0, K_PLAIN);
			7'd81: u = mk(ax(A_D,2), ax(A_D,2), 0, 0, 0, 1, A_DD, K_PLAIN);
			7'd82: u = mk(A_DLT, A_DD, 0, 1, 0, 0, A_V0, K_PLAIN);
			7'd83: u = mk(ax(A_N,0), ax(A_D,0), 0, 0, 1, 0, A_V0, K_PLAIN);
			7'd84: u = mk(ax(A_N,1), ax(A_D,1), 0, 0, 1, 0, A_V0, K_PLAIN);
			7'd85: u = mk(ax(A_N,2), ax(A_D,2), 0, 0, 1, 1, A_F, K_SIDE);
			default: u = mk(A_V0, A_V0, 1, 1, 0, 0, A_V0, K_PLAIN);
		endcase
		return u;
	endfunction

endpackage

>>> sv/csd_mac.sv
// ----------------------------------------------------------------------------
// csd_mac: shift-add multiply-accumulate unit
// Steps through the multiplier one bit per cycle, adding or subtracting the
// shifted multiplicand into a wrapping accumulator where the bit is set.
// ----------------------------------------------------------------------------
module csd_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csd_pkg::mac_ctl_t     ctl,
	input  logic [csd_pkg::W-1:0] op_a,
	input  logic [csd_pkg::W-1:0] op_b,
	output logic                  done,
	output logic [csd_pkg::W-1:0] acc
);
	import csd_pkg::*;

	logic         busy_q;
	logic [W-1:0] mcand_q;
	logic [W-1:0] mplier_q;
	logic         neg_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] addend;

	assign done   = busy_q && (mplier_q == '0);
	assign acc    = acc_q;
	assign addend = neg_q ? (~mcand_q + W'(1)) : mcand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q <= op_a;
			if (ctl.clr) begin
				acc_q <= '0;
			end
			if (ctl.bone) begin
				mplier_q <= W'(1);
				neg_q    <= ctl.neg;
			end else begin
				mplier_q <= op_b[W-1] ? (~op_b + W'(1)) : op_b;
				neg_q    <= ctl.neg ^ op_b[W-1];
			end
		end else if (busy_q && !done) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + addend;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule

>>> sv/circumsphere_depth_counter.sv
// ----------------------------------------------------------------------------
// circumsphere_depth_counter: exact integer in-sphere test
// Holds a tetrahedron, recomputes its circumsphere on each vertex load and
// classifies query points against it, counting points strictly inside up to the depth limit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | content
//  in      | sink      | in_valid/in_ready    | req_type, vertex_slot, coord_x/y/z
//  out     | source    | out_valid/out_ready  | result_kind ... limit_reached
//  cfg     | sink      | cfg_valid/cfg_ready  | cfg_data (depth limit)
//
// Each micro-operation passes the fetch, setup and multiply states, the last
// one stepping through the magnitude bits of its multiplier operand, all on
// the one shift-add accumulate unit. A load runs up to 73 micro-operations;
// a load that leaves a flat tetrahedron stops after 39. A test on a valid
// tetrahedron runs 13, a test on a degenerate one none. One request is in
// flight at a time; in_ready is low meanwhile. A result waiting on out_ready
// holds the block in its last state.
// Reset clears the vertices to zero and the depth limit to 2; cfg_ready is
// always high.
module circumsphere_depth_counter #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [1:0]            vertex_slot,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	input  logic [COORD_BITS-1:0] coord_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  result_kind,
	output logic                  centre_inside,
	output logic                  degenerate,
	output logic [1:0]            side_code,
	output logic [3:0]            inside_depth,
	output logic                  limit_reached,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_data
);
	import csd_pkg::*;

	localparam int DEPTH = 2 ** ADDR_W;

	state_t                state_q, state_d;
	pc_t                   pc_q;
	logic [1:0]            cnt_q;
	logic                  kind_q;
	logic [1:0]            slot_q;
	logic [COORD_BITS-1:0] crd_q [3];
	logic [1:0]            sign_q;
	logic                  inside_q;
	logic                  allpos_q;
	logic [1:0]            side_q;
	logic [3:0]            depth_q;
	logic [3:0]            limit_q;
	logic                  out_valid_q;
	logic                  out_kind_q;
	logic                  out_inside_q;
	logic                  out_degen_q;
	logic [1:0]            out_side_q;
	logic [3:0]            out_depth_q;
	logic                  out_limit_q;

	logic [W-1:0]          mem_q [DEPTH];
	logic [DEPTH-1:0]      vld_q;
	logic [W-1:0]          rda_s1, rdb_s1;
	logic                  va_s1, vb_s1;

	uop_t                  op;
	mac_ctl_t              mctl;
	logic                  mdone;
	logic [W-1:0]          macc;
	logic                  fin;
	logic                  acc_pos;
	logic                  acc_zero;
	logic                  we;
	addr_t                 waddr;
	logic [W-1:0]          wdata;
	logic [3:0]            depth_nx;
	logic                  take;

	assign op       = rom(pc_q);
	assign fin      = (state_q == ST_MUL) && mdone;
	assign acc_zero = (macc == '0);
	assign acc_pos  = !macc[W-1] && !acc_zero;
	assign take     = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	assign mctl.start = (state_q == ST_SETUP);
	assign mctl.bone  = op.bone;
	assign mctl.clr   = op.clr;
	assign mctl.neg   = op.neg;

	csd_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mctl),
		.op_a  (va_s1 ? rda_s1 : '0),
		.op_b  (vb_s1 ? rdb_s1 : '0),
		.done  (mdone),
		.acc   (macc)
	);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		we       = 1'b0;
		waddr    = op.dst;
		wdata    = macc;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_WRIN;
				end
			end
			ST_WRIN: begin
				we    = 1'b1;
				waddr = (kind_q == REQ_LOAD) ? ax(addr_t'({4'd0, slot_q} * 3), int'(cnt_q))
					: ax(A_Z, int'(cnt_q));
				wdata = {{(W-COORD_BITS){1'b0}}, crd_q[cnt_q]};
				if (cnt_q == 2'd2) begin
					if (kind_q == REQ_LOAD) begin
						state_d = ST_FETCH;
					end else if (sign_q == SGN_ZERO) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: state_d = ST_SETUP;
			ST_SETUP: state_d = ST_MUL;
			ST_MUL: begin
				if (fin) begin
					we = op.wr;
					if ((op.kind == K_DELTA && acc_zero) || op.kind == K_INSIDE
						|| op.kind == K_SIDE) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		depth_nx = depth_q;
		if (kind_q == REQ_LOAD) begin
			depth_nx = 4'd0;
		end else if (side_q == SIDE_IN && depth_q < limit_q) begin
			depth_nx = depth_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= PC_LOAD;
			cnt_q       <= 2'd0;
			sign_q      <= SGN_ZERO;
			inside_q    <= 1'b0;
			allpos_q    <= 1'b0;
			depth_q     <= 4'd0;
			limit_q     <= 4'd2;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (state_q == ST_DONE && take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: cnt_q <= 2'd0;
				ST_WRIN: begin
					cnt_q <= cnt_q + 2'd1;
					pc_q  <= (kind_q == REQ_LOAD) ? PC_LOAD : PC_SIDE;
				end
				ST_MUL: begin
					if (fin) begin
						pc_q <= pc_q + pc_t'(1);
						case (op.kind)
							K_DELTA: begin
								allpos_q <= 1'b1;
								if (acc_zero) begin
									sign_q   <= SGN_ZERO;
									inside_q <= 1'b0;
								end else begin
									sign_q <= macc[W-1] ? SGN_NEG : SGN_POS;
								end
							end
							K_CHK:    allpos_q <= allpos_q & acc_pos;
							K_INSIDE: inside_q <= allpos_q & acc_pos;
							default: ;
						endcase
					end
				end
				ST_DONE: begin
					if (take) begin
						depth_q <= depth_nx;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			kind_q   <= req_type;
			slot_q   <= vertex_slot;
			crd_q[0] <= coord_x;
			crd_q[1] <= coord_y;
			crd_q[2] <= coord_z;
		end
		if (state_q == ST_WRIN) begin
			side_q <= SIDE_ON;
		end
		if (fin && op.kind == K_SIDE) begin
			if (acc_zero) begin
				side_q <= SIDE_ON;
			end else if (macc[W-1] == (sign_q == SGN_POS)) begin
				side_q <= SIDE_IN;
			end else begin
				side_q <= SIDE_OUT;
			end
		end
		if (state_q == ST_DONE && take) begin
			out_kind_q   <= kind_q;
			out_inside_q <= inside_q;
			out_degen_q  <= (sign_q == SGN_ZERO);
			out_side_q   <= (kind_q == REQ_TEST) ? side_q : SIDE_IN;
			out_depth_q  <= depth_nx;
			out_limit_q  <= (depth_nx >= limit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (state_q == ST_FETCH) begin
			rda_s1 <= mem_q[op.a];
			rdb_s1 <= mem_q[op.b];
			va_s1  <= vld_q[op.a];
			vb_s1  <= vld_q[op.b];
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = out_kind_q;
	assign centre_inside = out_inside_q;
	assign degenerate    = out_degen_q;
	assign side_code     = out_side_q;
	assign inside_depth  = out_depth_q;
	assign limit_reached = out_limit_q;

endmodule

>>> sv/csd_chk.sv
// ----------------------------------------------------------------------------
// csd_chk: port-level checks
// Watches the request and result channels of the circumsphere depth counter.
// ----------------------------------------------------------------------------
module csd_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       result_kind,
	input logic       centre_inside,
	input logic       degenerate,
	input logic [1:0] side_code,
	input logic [3:0] inside_depth
);
	import csd_pkg::*;

	// Only one request is in flight, so the port closes after each accept.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another was in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(side_code)
			&& $stable(inside_depth) && $stable(result_kind))
		else $error("stalled result changed");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == REQ_LOAD |-> side_code == SIDE_IN
			&& inside_depth == 4'd0)
		else $error("load result carries a test side or depth");

	a_degen_contact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> !centre_inside
			&& (result_kind == REQ_LOAD || side_code == SIDE_ON))
		else $error("degenerate tetrahedron gave a non-contact answer");

endmodule

bind circumsphere_depth_counter csd_chk u_csd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_kind  (result_kind),
	.centre_inside(centre_inside),
	.degenerate   (degenerate),
	.side_code    (side_code),
	.inside_depth (inside_depth)
);
